@@ design/scgd_pkg.sv @@
// Shared types and constants for the subset-count-by-difference block.
// No dependencies; every other file in the design folder imports this package.
package scgd_pkg;

	localparam int ELEM_W  = 10;
	localparam int DIFF_W  = 10;
	localparam int COUNT_W = 32;
	localparam int TOTAL_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_DRAIN,
		ST_LOOKUP,
		ST_REPORT
	} state_t;

	// One result beat as handed from the sequencer to the output register.
	typedef struct packed {
		logic [COUNT_W-1:0] subset_count;
		logic               count_saturated;
		logic               target_out_of_range;
	} result_t;

endpackage

@@ design/scgd_channels.sv @@
// Valid/ready channel interfaces: configuration, element input and result output.
// Depends on scgd_pkg for the field widths.
interface scgd_cfg_if;
	import scgd_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIFF_W-1:0] difference;
	modport source (output valid, output difference, input ready);
	modport sink (input valid, input difference, output ready);
endinterface

interface scgd_elem_if;
	import scgd_pkg::*;
	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] elem_value;
	logic              elem_last;
	modport source (output valid, output elem_value, output elem_last, input ready);
	modport sink (input valid, input elem_value, input elem_last, output ready);
endinterface

interface scgd_result_if;
	import scgd_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] subset_count;
	logic               count_saturated;
	logic               target_out_of_range;
	modport source (output valid, output subset_count, output count_saturated,
		output target_out_of_range, input ready);
	modport sink (input valid, input subset_count, input count_saturated,
		input target_out_of_range, output ready);
endinterface

@@ design/scgd_sat_add.sv @@
// Shared saturating adder for subset-count table entries.
// Depends on scgd_pkg for the count width and saturation value.
module scgd_sat_add (
	input  logic [scgd_pkg::COUNT_W-1:0] a,
	input  logic [scgd_pkg::COUNT_W-1:0] b,
	output logic [scgd_pkg::COUNT_W-1:0] sum,
	output logic                         ovf
);
	import scgd_pkg::*;

	logic [COUNT_W:0] raw;

	// Full-width add, clamp on carry out.
	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		ovf = raw[COUNT_W];
		sum = raw[COUNT_W] ? COUNT_MAX : raw[COUNT_W-1:0];
	end

endmodule

@@ design/scgd_table.sv @@
// Count table memory: one write port and two read ports with registered read data.
// Depends on scgd_pkg for the entry width.
module scgd_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [scgd_pkg::COUNT_W-1:0] wr_data,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr_a,
	input  logic [AW-1:0]                rd_addr_b,
	output logic [scgd_pkg::COUNT_W-1:0] rd_data_a,
	output logic [scgd_pkg::COUNT_W-1:0] rd_data_b
);
	import scgd_pkg::*;

	logic [COUNT_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Two read ports; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

@@ design/scgd_ctrl.sv @@
// Sequencer: walks the count table once per element up to MAX_SUM through the shared adder,
// keeps the running total, looks up the target and runs the clearing pass.
// Depends on scgd_pkg, scgd_sat_add and an external scgd_table.
module scgd_ctrl #(
	parameter int MAX_SUM = 1023,
	parameter int AW      = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [scgd_pkg::DIFF_W-1:0]  difference,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [scgd_pkg::ELEM_W-1:0]  elem_value,
	input  logic                         elem_last,
	input  logic                         slot_free,
	output logic                         push,
	output scgd_pkg::result_t            res,
	output logic                         mem_wr_en,
	output logic [AW-1:0]                mem_wr_addr,
	output logic [scgd_pkg::COUNT_W-1:0] mem_wr_data,
	output logic                         mem_rd_en,
	output logic [AW-1:0]                mem_rd_addr_a,
	output logic [AW-1:0]                mem_rd_addr_b,
	input  logic [scgd_pkg::COUNT_W-1:0] mem_rd_data_a,
	input  logic [scgd_pkg::COUNT_W-1:0] mem_rd_data_b
);
	import scgd_pkg::*;

	localparam int XW = (AW > ELEM_W) ? AW : ELEM_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SUM);

	state_t             st_q;
	state_t             st_d;
	logic [AW-1:0]      j_q;
	logic [AW-1:0]      lowest_q;
	logic [ELEM_W-1:0]  v_q;
	logic               last_q;
	logic [TOTAL_W-1:0] total_q;
	logic               sat_q;
	logic               rd_valid_s1;
	logic [AW-1:0]      wr_addr_s1;

	logic               accept;
	logic               v_fits;
	logic [TOTAL_W:0]   total_sum;
	logic [TOTAL_W-1:0] total_next;
	logic [TOTAL_W:0]   target_sum;
	logic [TOTAL_W-1:0] target;
	logic               in_range;
	logic [XW-1:0]      j_minus_v;
	logic [COUNT_W-1:0] add_sum;
	logic               add_ovf;

	// Shared saturating adder: old entry plus the entry v below it.
	scgd_sat_add u_add (
		.a   (mem_rd_data_a),
		.b   (mem_rd_data_b),
		.sum (add_sum),
		.ovf (add_ovf)
	);

	// Element arithmetic: fit check, running total, target and lower read address.
	always_comb begin
		accept     = in_valid && in_ready;
		v_fits     = XW'(elem_value) <= XW'(MAX_SUM);
		total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(elem_value);
		total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
		target_sum = (TOTAL_W+1)'(difference) + {1'b0, total_q};
		target     = target_sum[TOTAL_W:1];
		in_range   = target <= TOTAL_W'(MAX_SUM);
		j_minus_v  = XW'(j_q) - XW'(v_q);
	end

	// Next-state logic.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (j_q == LAST_ADDR) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (v_fits) st_d = ST_UPDATE;
					else if (elem_last) st_d = ST_LOOKUP;
				end
			end
			ST_UPDATE: begin
				if (j_q == lowest_q) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				st_d = last_q ? ST_LOOKUP : ST_IDLE;
			end
			ST_LOOKUP: begin
				st_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (slot_free) st_d = ST_CLEAR;
			end
			default: begin
				st_d = ST_CLEAR;
			end
		endcase
	end

	// Output decode: handshake, table ports and result beat.
	always_comb begin
		in_ready      = 1'b0;
		push          = 1'b0;
		mem_rd_en     = 1'b0;
		mem_rd_addr_a = j_q;
		mem_rd_addr_b = j_minus_v[AW-1:0];
		mem_wr_en     = rd_valid_s1;
		mem_wr_addr   = wr_addr_s1;
		mem_wr_data   = add_sum;
		unique case (st_q)
			ST_CLEAR: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = j_q;
				mem_wr_data = (j_q == '0) ? COUNT_W'(1) : '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_UPDATE: begin
				mem_rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_LOOKUP: begin
				mem_rd_en     = 1'b1;
				mem_rd_addr_a = target[AW-1:0];
			end
			ST_REPORT: begin
				push = slot_free;
			end
			default: begin
			end
		endcase
		res.subset_count        = in_range ? mem_rd_data_a : '0;
		res.count_saturated     = sat_q;
		res.target_out_of_range = !in_range;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// Table walk counter, shared by the clearing pass and the element walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else begin
			case (st_q)
				ST_CLEAR:  j_q <= (j_q == LAST_ADDR) ? LAST_ADDR : j_q + AW'(1);
				ST_IDLE:   if (accept) j_q <= LAST_ADDR;
				ST_UPDATE: j_q <= j_q - AW'(1);
				ST_REPORT: if (slot_free) j_q <= '0;
				default:   j_q <= j_q;
			endcase
		end
	end

	// Element registers captured on the input beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q      <= elem_value;
			last_q   <= elem_last;
			lowest_q <= (elem_value == '0) ? AW'(1) : AW'(elem_value);
		end
	end

	// Read-to-write pipeline stage of the walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (st_q == ST_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= j_q;
	end

	// Running total and saturation flag of the current set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			sat_q   <= 1'b0;
		end else if (push) begin
			total_q <= '0;
			sat_q   <= 1'b0;
		end else begin
			if (accept) total_q <= total_next;
			if (rd_valid_s1 && add_ovf) sat_q <= 1'b1;
		end
	end

	// The write pipeline is empty whenever the block can take an element.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_valid_s1)
		else $error("pending table write while ready");

	// The clearing pass never collides with a walk write.
	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CLEAR |-> !rd_valid_s1)
		else $error("walk write during clearing pass");

	// The walk never reads below entry zero.
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_UPDATE |-> (j_q >= lowest_q) && (XW'(j_q) >= XW'(v_q)))
		else $error("table walk out of bounds");

	// A result beat is followed by a clearing pass from entry zero.
	a_push_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (st_q == ST_CLEAR) && (j_q == '0) && (total_q == '0))
		else $error("no clearing pass after result");

endmodule

@@ design/subset_count_given_difference.sv @@
// Counts the subsets of a streamed set whose split meets a given sum difference.
// An element beat of value v (1..MAX_SUM) occupies the block while the table walk
// runs from entry MAX_SUM down to entry v, a zero element walks down to entry 1 and
// an element above MAX_SUM is taken with no walk; the walk updates one count entry per
// cycle through the single table write port and one shared saturating adder. The beat
// marked last adds a target lookup and, once the result register is free, a clearing
// pass over all MAX_SUM + 1 entries; the same pass runs after reset before the first
// element is taken. The result beat waits in an output register while clearing runs.
// Depends on scgd_pkg, scgd_channels, scgd_ctrl, scgd_table and scgd_sat_add.
module subset_count_given_difference #(
	parameter int MAX_SUM = 1023
) (
	input  logic                 clk,
	input  logic                 arst_n,
	scgd_cfg_if.sink             cfg,
	scgd_elem_if.sink            elem,
	scgd_result_if.source        result
);
	import scgd_pkg::*;

	localparam int DEPTH = MAX_SUM + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [DIFF_W-1:0]  difference_q;
	logic               res_valid_q;
	result_t            res_q;
	result_t            res;
	logic               slot_free;
	logic               push;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic [COUNT_W-1:0] mem_wr_data;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr_a;
	logic [AW-1:0]      mem_rd_addr_b;
	logic [COUNT_W-1:0] mem_rd_data_a;
	logic [COUNT_W-1:0] mem_rd_data_b;

	// Difference register, always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			difference_q <= '0;
		end else if (cfg.valid) begin
			difference_q <= cfg.difference;
		end
	end

	// Output register between the sequencer and the result channel.
	assign slot_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.subset_count        = res_q.subset_count;
	assign result.count_saturated     = res_q.count_saturated;
	assign result.target_out_of_range = res_q.target_out_of_range;

	// Sequencer with the shared adder.
	scgd_ctrl #(
		.MAX_SUM (MAX_SUM),
		.AW      (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.difference    (difference_q),
		.in_valid      (elem.valid),
		.in_ready      (elem.ready),
		.elem_value    (elem.elem_value),
		.elem_last     (elem.elem_last),
		.slot_free     (slot_free),
		.push          (push),
		.res           (res),
		.mem_wr_en     (mem_wr_en),
		.mem_wr_addr   (mem_wr_addr),
		.mem_wr_data   (mem_wr_data),
		.mem_rd_en     (mem_rd_en),
		.mem_rd_addr_a (mem_rd_addr_a),
		.mem_rd_addr_b (mem_rd_addr_b),
		.mem_rd_data_a (mem_rd_data_a),
		.mem_rd_data_b (mem_rd_data_b)
	);

	// Subset-sum count table.
	scgd_table #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (mem_rd_en),
		.rd_addr_a (mem_rd_addr_a),
		.rd_addr_b (mem_rd_addr_b),
		.rd_data_a (mem_rd_data_a),
		.rd_data_b (mem_rd_data_b)
	);

endmodule
